// File: rtl/core/ps2hl_pkg.sv
`default_nettype none
package ps2hl_pkg;

   localparam logic [7:0] ACK_CODE = 8'hFA;

   localparam logic ACTION_EDGE = 1'b0;
   localparam logic ACTION_SEND = 1'b1;

   // frame positions
   localparam logic [3:0] POS_PARITY = 4'd8;
   localparam logic [3:0] POS_STOP   = 4'd9;

   typedef enum logic [2:0] {
      MODE_RX  = 3'b001,
      MODE_TX  = 3'b010,
      MODE_ACK = 3'b100
   } link_mode_type;

   typedef struct packed {
      logic       action;
      logic       data_bit;
      logic [7:0] send_byte;
   } req_payload_type;

   typedef struct packed {
      logic       data_drive;
      logic       rts_start;
      logic       byte_valid;
      logic [7:0] rx_byte;
      logic       start_error;
      logic       parity_error;
      logic       stop_error;
      logic       is_ack_response;
      logic       ack_error;
      logic       line_control_error;
      logic       tx_done;
      logic       send_rejected;
   } rsp_payload_type;

endpackage
`default_nettype wire

// File: rtl/core/ps2hl_if.sv
`default_nettype none
interface ps2hl_req_if import ps2hl_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface ps2hl_rsp_if import ps2hl_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: rtl/core/ps2_host_link_controller_core.sv
`default_nettype none
// an accepted req beat's rsp beat is registered and offered in the next cycle
// throughput: one beat per cycle when rsp is ready; the output register lets a
//   new req beat enter in the same cycle that the waiting rsp beat is taken
// reset (synchronous, active high): receive mode, bit position and shift state
//   cleared, transmit parity set to one, no rsp beat pending
module ps2_host_link_controller_core import ps2hl_pkg::*; (
   input  wire          clock,
   input  wire          reset,
   ps2hl_req_if.sink    req,
   ps2hl_rsp_if.source  rsp
);

   link_mode_type   mode_ff, mode_in;
   logic [3:0]      pos_ff, pos_in;
   logic [7:0]      rx_shift_ff, rx_shift_in;
   logic            rx_parity_ff, rx_parity_in;
   logic            rx_start_bad_ff, rx_start_bad_in;
   logic [7:0]      tx_shift_ff, tx_shift_in;
   logic            tx_parity_ff, tx_parity_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            accept;
   logic [2:0]      rx_idx;
   logic            bit_in;
   logic            ack_wait;

   assign req.ready   = !rsp_valid_ff || rsp.ready;
   assign accept      = req.valid && req.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   assign bit_in   = req.payload.data_bit;
   assign rx_idx   = 3'(pos_ff - 4'd1);
   assign ack_wait = (mode_ff == MODE_ACK);

   always_comb begin
      mode_in         = mode_ff;
      pos_in          = pos_ff;
      rx_shift_in     = rx_shift_ff;
      rx_parity_in    = rx_parity_ff;
      rx_start_bad_in = rx_start_bad_ff;
      tx_shift_in     = tx_shift_ff;
      tx_parity_in    = tx_parity_ff;
      rsp_data_in     = '0;
      rsp_data_in.data_drive = 1'b1;

      if (req.payload.action == ACTION_SEND) begin
         if (mode_ff == MODE_TX || mode_ff == MODE_ACK) begin
            rsp_data_in.send_rejected = 1'b1;
         end else begin
            // partial receive frame is dropped
            pos_in          = '0;
            rx_shift_in     = '0;
            rx_parity_in    = 1'b0;
            rx_start_bad_in = 1'b0;
            tx_shift_in     = req.payload.send_byte;
            tx_parity_in    = 1'b1;
            mode_in         = MODE_TX;
            rsp_data_in.data_drive = 1'b0;
            rsp_data_in.rts_start  = 1'b1;
         end
      end else if (mode_ff == MODE_TX) begin
         if (pos_ff < POS_PARITY) begin
            tx_parity_in = tx_parity_ff ^ tx_shift_ff[0];
            tx_shift_in  = tx_shift_ff >> 1;
            rsp_data_in.data_drive = tx_shift_ff[0];
            pos_in = pos_ff + 4'd1;
         end else if (pos_ff == POS_PARITY) begin
            rsp_data_in.data_drive = tx_parity_ff;
            pos_in = pos_ff + 4'd1;
         end else if (pos_ff == POS_STOP) begin
            pos_in = pos_ff + 4'd1;
         end else begin
            // line-control edge
            rsp_data_in.line_control_error = bit_in;
            rsp_data_in.tx_done            = 1'b1;
            pos_in          = '0;
            rx_shift_in     = '0;
            rx_parity_in    = 1'b0;
            rx_start_bad_in = 1'b0;
            mode_in         = MODE_ACK;
         end
      end else begin
         if (pos_ff == 4'd0) begin
            rx_start_bad_in = bit_in;
            pos_in = pos_ff + 4'd1;
         end else if (pos_ff <= POS_PARITY) begin
            rx_shift_in[rx_idx] = rx_shift_ff[rx_idx] | bit_in;
            rx_parity_in = rx_parity_ff ^ bit_in;
            pos_in = pos_ff + 4'd1;
         end else if (pos_ff == POS_STOP) begin
            rx_parity_in = rx_parity_ff ^ bit_in;
            pos_in = pos_ff + 4'd1;
         end else begin
            rsp_data_in.byte_valid      = 1'b1;
            rsp_data_in.rx_byte         = rx_shift_ff;
            rsp_data_in.start_error     = rx_start_bad_ff;
            rsp_data_in.parity_error    = !rx_parity_ff;
            rsp_data_in.stop_error      = !bit_in;
            rsp_data_in.is_ack_response = ack_wait;
            rsp_data_in.ack_error       = ack_wait && (rx_shift_ff != ACK_CODE);
            pos_in          = '0;
            rx_shift_in     = '0;
            rx_parity_in    = 1'b0;
            rx_start_bad_in = 1'b0;
            mode_in         = MODE_RX;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_RX;
         pos_ff          <= '0;
         rx_shift_ff     <= '0;
         rx_parity_ff    <= 1'b0;
         rx_start_bad_ff <= 1'b0;
         tx_shift_ff     <= '0;
         tx_parity_ff    <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff         <= mode_in;
            pos_ff          <= pos_in;
            rx_shift_ff     <= rx_shift_in;
            rx_parity_ff    <= rx_parity_in;
            rx_start_bad_ff <= rx_start_bad_in;
            tx_shift_ff     <= tx_shift_in;
            tx_parity_ff    <= tx_parity_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps

module tb;
   import ps2hl_pkg::*;

   localparam int HOLD_OFF_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int TAIL_CYCLES     = 8;

   logic clock;
   logic reset;

   ps2hl_req_if req_ch ();
   ps2hl_rsp_if rsp_ch ();

   ps2_host_link_controller_core i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // link state as the testbench sees it
   link_mode_type link_state      = MODE_RX;
   logic [3:0]    frame_pos       = 4'd0;
   logic [7:0]    rx_data_acc     = 8'h00;
   logic          rx_parity_acc   = 1'b0;
   logic          start_seen_high = 1'b0;
   logic [7:0]    tx_data_left    = 8'h00;
   logic          tx_parity_acc   = 1'b1;

   rsp_payload_type pending_rsp[$];

   bit idle_on       = 1'b0;
   bit hold_off_req  = 1'b0;
   int mismatches    = 0;
   int beats_sent    = 0;
   int quiet_cycles  = 0;
   int frames_seen   = 0;
   int acks_seen     = 0;
   int sends_started = 0;
   int sends_refused = 0;
   int tx_finished   = 0;
   int flagged_errs  = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void drop_frame();
      frame_pos       = 4'd0;
      rx_data_acc     = 8'h00;
      rx_parity_acc   = 1'b0;
      start_seen_high = 1'b0;
   endfunction

   function automatic rsp_payload_type predict_link_response(input req_payload_type beat);
      rsp_payload_type r;
      logic            ack_wait;
      r = '0;
      r.data_drive = 1'b1;
      if (beat.action == ACTION_SEND) begin
         if (link_state != MODE_RX) begin
            r.send_rejected = 1'b1;
         end else begin
            drop_frame();
            tx_data_left  = beat.send_byte;
            tx_parity_acc = 1'b1;
            link_state    = MODE_TX;
            r.data_drive  = 1'b0;
            r.rts_start   = 1'b1;
         end
      end else if (link_state == MODE_TX) begin
         if (frame_pos < POS_PARITY) begin
            r.data_drive  = tx_data_left[0];
            tx_parity_acc = tx_parity_acc ^ tx_data_left[0];
            tx_data_left  = tx_data_left >> 1;
            frame_pos++;
         end else if (frame_pos == POS_PARITY) begin
            r.data_drive = tx_parity_acc;
            frame_pos++;
         end else if (frame_pos == POS_STOP) begin
            frame_pos++;
         end else begin
            // line-control edge closes the host frame
            r.line_control_error = beat.data_bit;
            r.tx_done            = 1'b1;
            drop_frame();
            link_state = MODE_ACK;
         end
      end else begin
         if (frame_pos == 4'd0) begin
            start_seen_high = beat.data_bit;
            frame_pos++;
         end else if (frame_pos <= POS_PARITY) begin
            rx_data_acc[3'(frame_pos - 4'd1)] = beat.data_bit;
            rx_parity_acc = rx_parity_acc ^ beat.data_bit;
            frame_pos++;
         end else if (frame_pos == POS_STOP) begin
            rx_parity_acc = rx_parity_acc ^ beat.data_bit;
            frame_pos++;
         end else begin
            ack_wait          = (link_state == MODE_ACK);
            r.byte_valid      = 1'b1;
            r.rx_byte         = rx_data_acc;
            r.start_error     = start_seen_high;
            r.parity_error    = (rx_parity_acc != 1'b1);
            r.stop_error      = (beat.data_bit != 1'b1);
            r.is_ack_response = ack_wait;
            r.ack_error       = ack_wait && (rx_data_acc != ACK_CODE);
            drop_frame();
            link_state = MODE_RX;
         end
      end
      return r;
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         mismatches++;
      end
   endfunction

   function automatic void compare_result(input rsp_payload_type want,
                                          input rsp_payload_type got);
      check_field("data_drive", 8'(want.data_drive), 8'(got.data_drive));
      check_field("rts_start", 8'(want.rts_start), 8'(got.rts_start));
      check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      check_field("rx_byte", want.rx_byte, got.rx_byte);
      check_field("start_error", 8'(want.start_error), 8'(got.start_error));
      check_field("parity_error", 8'(want.parity_error), 8'(got.parity_error));
      check_field("stop_error", 8'(want.stop_error), 8'(got.stop_error));
      check_field("is_ack_response", 8'(want.is_ack_response), 8'(got.is_ack_response));
      check_field("ack_error", 8'(want.ack_error), 8'(got.ack_error));
      check_field("line_control_error", 8'(want.line_control_error),
                  8'(got.line_control_error));
      check_field("tx_done", 8'(want.tx_done), 8'(got.tx_done));
      check_field("send_rejected", 8'(want.send_rejected), 8'(got.send_rejected));
   endfunction

   // result checking, prediction and watchdog
   always @(posedge clock) begin : monitor_blk
      rsp_payload_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
               $error("result beat 0x%0h with nothing expected", rsp_ch.payload);
               mismatches++;
            end else begin
               want = pending_rsp.pop_front();
               compare_result(want, rsp_ch.payload);
               frames_seen   += int'(want.byte_valid);
               acks_seen     += int'(want.is_ack_response);
               sends_started += int'(want.rts_start);
               sends_refused += int'(want.send_rejected);
               tx_finished   += int'(want.tx_done);
               flagged_errs  += int'(want.start_error) + int'(want.parity_error)
                                + int'(want.stop_error) + int'(want.ack_error)
                                + int'(want.line_control_error);
            end
         end
         if (req_ch.valid && req_ch.ready)
            pending_rsp.push_back(predict_link_response(req_ch.payload));
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[ps2_host_link_controller_core] ERROR");
            $finish;
         end
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(0, 8)) @(negedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // called at a falling edge; returns at the falling edge after the beat is taken
   task automatic send_beat(input req_payload_type beat);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= beat;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   task automatic send_edge(input logic level);
      req_payload_type beat;
      beat.action    = ACTION_EDGE;
      beat.data_bit  = level;
      beat.send_byte = 8'($urandom_range(0, 255));
      send_beat(beat);
   endtask

   task automatic send_request(input logic [7:0] value);
      req_payload_type beat;
      beat.action    = ACTION_SEND;
      beat.data_bit  = 1'($urandom_range(0, 1));
      beat.send_byte = value;
      send_beat(beat);
   endtask

   task automatic send_frame(input logic [7:0] value, input bit bad_start,
                             input bit bad_parity, input bit bad_stop);
      send_edge(bad_start);
      for (int i = 0; i < 8; i++)
         send_edge(value[i]);
      send_edge((~^value) ^ bad_parity);
      send_edge(~bad_stop);
   endtask

   // clock edges with random data until the link is back at a frame boundary
   task automatic realign_link();
      while (link_state == MODE_TX || frame_pos != 4'd0)
         send_edge(1'($urandom_range(0, 1)));
   endtask

   task automatic drain_link();
      req_ch.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_frame(input logic [7:0] value);
      send_frame(value, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0,
                 $urandom_range(0, 7) == 0);
   endtask

   task automatic host_transaction();
      send_request(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0)
         send_request(8'($urandom_range(0, 255)));
      repeat (10) send_edge(1'($urandom_range(0, 1)));
      send_edge($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0)
         send_request(8'($urandom_range(0, 255)));
      send_random_frame($urandom_range(0, 1) ? ACK_CODE : 8'($urandom_range(0, 255)));
   endtask

   task automatic test_host_send_and_ack();
      send_request(8'h00);
      send_request(8'hFF);                       // refused mid-transmit
      repeat (10) send_edge(1'($urandom_range(0, 1)));
      send_edge(1'b0);
      send_request(8'h5A);                       // refused while waiting for the response
      send_frame(ACK_CODE, 1'b0, 1'b0, 1'b0);
   endtask

   task automatic test_partial_frame_dropped();
      send_edge(1'b0);
      send_edge(1'b1);
      send_edge(1'b1);
      send_request(8'hFF);
      repeat (10) send_edge(1'($urandom_range(0, 1)));
      send_edge(1'b1);                           // line-control bit high
      send_frame(8'h01, 1'b1, 1'b1, 1'b1);
   endtask

   task automatic test_backpressure();
      hold_off_req = 1'b1;
      repeat (3) send_random_frame(8'($urandom_range(0, 255)));
   endtask

   task automatic test_sender_pause();
      host_transaction();
      drain_link();
      send_random_frame(8'($urandom_range(0, 255)));
   endtask

   task automatic run_random_traffic(input int n_beats);
      int target;
      int pick;
      req_payload_type beat;
      target = beats_sent + n_beats;
      while (beats_sent < target) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            send_random_frame(8'($urandom_range(0, 255)));
         end else if (pick < 8) begin
            host_transaction();
         end else begin
            // broken sequences: stray edges and sends at random frame positions
            repeat ($urandom_range(1, 6)) begin
               beat.action    = ($urandom_range(0, 3) == 0) ? ACTION_SEND : ACTION_EDGE;
               beat.data_bit  = 1'($urandom_range(0, 1));
               beat.send_byte = 8'($urandom_range(0, 255));
               send_beat(beat);
            end
            realign_link();
         end
      end
   endtask

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      reset          = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_on = 1'b1;
      test_host_send_and_ack();
      test_partial_frame_dropped();
      test_backpressure();
      test_sender_pause();
      run_random_traffic(1050);
      idle_on = 1'b0;
      run_random_traffic(180);
      drain_link();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d beats: %0d frames received, %0d of them responses to a send",
               beats_sent, frames_seen, acks_seen);
      $display("host sends: %0d started, %0d completed, %0d refused; %0d error flags raised",
               sends_started, tx_finished, sends_refused, flagged_errs);
      if (mismatches == 0)
         $display("[ps2_host_link_controller_core] OK");
      else
         $display("[ps2_host_link_controller_core] ERROR");
      $finish;
   end

endmodule
